>>> hw/rtl/bsics_pkg.sv
// types, constants and helper functions for the binned spectrum sampler
// used by every module under hw/rtl; depends on nothing
`default_nettype none
package bsics_pkg;

  localparam int SPEC_DEPTH = 1024;
  localparam int RESP_DEPTH = 1024;
  localparam int SPEC_AW    = $clog2(SPEC_DEPTH);
  localparam int RESP_AW    = $clog2(RESP_DEPTH);
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_SPEC_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_COUNT = 1'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_SPEC = 2'd0,
    CMD_LOAD_RESP = 2'd1,
    CMD_FOLD      = 2'd2,
    CMD_SAMPLE    = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FI_RD,
    S_FI_LAT,
    S_FJ_RD,
    S_FJ_OV,
    S_FJ_ACC,
    S_FI_MH,
    S_FI_ML,
    S_FI_RATE,
    S_SM_RD,
    S_SM_TOT,
    S_SM_M2,
    S_SM_TGT,
    S_SB_RD,
    S_SB_CMP,
    S_SE_RD,
    S_SE_LAT,
    S_SE_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  entry_index;
    logic [23:0] edge_low;
    logic [23:0] edge_high;
    logic [31:0] bin_weight;
    logic [23:0] uniform_pick;
    logic [23:0] uniform_spread;
  } item_t;

  typedef struct packed {
    logic [23:0] photon_energy;
    logic [9:0]  chosen_bin;
    logic [47:0] total_rate;
    logic        result_status;
  } result_t;

  typedef struct packed {
    logic [23:0] low;
    logic [23:0] high;
    logic [31:0] weight;
  } bin_entry_t;

  typedef struct packed {
    logic               spec_we;
    logic [SPEC_AW-1:0] spec_addr;
    bin_entry_t         spec_wdata;
    logic               resp_we;
    logic [RESP_AW-1:0] resp_addr;
    bin_entry_t         resp_wdata;
    logic               cum_we;
    logic [SPEC_AW-1:0] cum_addr;
    logic [47:0]        cum_wdata;
  } store_req_t;

  // zero acts as one, anything above the depth acts as the depth
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] depth);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = {{(CNT_W-1){1'b0}}, 1'b1};
    else if (c > depth) r = depth;
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic [49:0] v);
    logic [47:0] r;
    r = v[47:0];
    if (v[49:48] != 2'b00) r = SAT48;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/binned_spectrum_inverse_cdf_sampler.sv
// binned spectrum inverse-cdf sampler, top level
// loads write one table entry; sample searches the cumulative rates and interpolates
// fold: its time is set by the walk over the response memory and the one
// shared multiplier. one beat in flight at a time; done pulses one cycle, no stall
// sync reset clears control and sets both bin counts to 1; tables are unset until written
`default_nettype none
module binned_spectrum_inverse_cdf_sampler (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire bsics_pkg::item_t                 item,
  output logic                                  done,
  output bsics_pkg::result_t                    result,
  input  wire logic                             cfg_we,
  input  wire logic [bsics_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsics_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsics_pkg::*;

  store_req_t  req;
  bin_entry_t  spec_rdata, resp_rdata;
  logic [47:0] cum_rdata;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  bsics_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .spec_rdata(spec_rdata), .resp_rdata(resp_rdata), .cum_rdata(cum_rdata),
    .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p)
  );

  bsics_store u_store (
    .clk(clk), .req(req), .spec_rdata(spec_rdata), .resp_rdata(resp_rdata),
    .cum_rdata(cum_rdata)
  );

  bsics_mul u_mul (
    .clk(clk), .op_a(mul_a), .op_b(mul_b), .product(mul_p)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_err_no_energy: assert property (@(posedge clk) disable iff (rst)
    (done && result.result_status) |-> (result.photon_energy == 24'd0 &&
                                        result.total_rate == 48'd0))
    else $error("error beat carries data");

endmodule
`default_nettype wire

>>> hw/rtl/bsics_mul.sv
// shared 32x32 unsigned multiplier with registered product
// depends on bsics_pkg
`default_nettype none
module bsics_mul (
  input  wire logic        clk,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic      [63:0] product
);
  import bsics_pkg::*;

  always_ff @(posedge clk) begin
    product <= {32'd0, op_a} * {32'd0, op_b};
  end

endmodule
`default_nettype wire

>>> hw/rtl/bsics_store.sv
// spectrum, response and cumulative rate memories, one port each
// depends on bsics_pkg
`default_nettype none
module bsics_store (
  input  wire logic                 clk,
  input  wire bsics_pkg::store_req_t req,
  output bsics_pkg::bin_entry_t     spec_rdata,
  output bsics_pkg::bin_entry_t     resp_rdata,
  output logic [47:0]               cum_rdata
);
  import bsics_pkg::*;

  bin_entry_t  spec_mem [SPEC_DEPTH];
  bin_entry_t  resp_mem [RESP_DEPTH];
  logic [47:0] cum_mem  [SPEC_DEPTH];

  always_ff @(posedge clk) begin
    if (req.spec_we) begin
      spec_mem[req.spec_addr] <= req.spec_wdata;
    end
    spec_rdata <= spec_mem[req.spec_addr];
  end

  always_ff @(posedge clk) begin
    if (req.resp_we) begin
      resp_mem[req.resp_addr] <= req.resp_wdata;
    end
    resp_rdata <= resp_mem[req.resp_addr];
  end

  always_ff @(posedge clk) begin
    if (req.cum_we) begin
      cum_mem[req.cum_addr] <= req.cum_wdata;
    end
    cum_rdata <= cum_mem[req.cum_addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/bsics_ctrl.sv
// sequencer and datapath registers: load, fold walk, search and interpolation
// depends on bsics_pkg; drives bsics_store and bsics_mul
`default_nettype none
module bsics_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire bsics_pkg::item_t                 item,
  output logic                                  done,
  output bsics_pkg::result_t                    result,
  input  wire logic                             cfg_we,
  input  wire logic [bsics_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsics_pkg::CFG_DATA_W-1:0] cfg_data,
  output bsics_pkg::store_req_t                 req,
  input  wire bsics_pkg::bin_entry_t            spec_rdata,
  input  wire bsics_pkg::bin_entry_t            resp_rdata,
  input  wire logic [47:0]                      cum_rdata,
  output logic [31:0]                           mul_a,
  output logic [31:0]                           mul_b,
  input  wire logic [63:0]                      mul_p
);
  import bsics_pkg::*;

  state_e state, state_next;

  logic [CNT_W-1:0] spec_cnt, resp_cnt;
  logic [CNT_W-1:0] n_eff, m_eff;
  logic [SPEC_AW-1:0] n_last;
  logic [RESP_AW-1:0] m_last;

  item_t cur;
  logic [SPEC_AW-1:0] i, i_next, lower, lower_next, upper, upper_next, mid, mid_next;
  logic [RESP_AW-1:0] j, j_next;
  logic [23:0] sl, sl_next, sh, sh_next;
  logic [31:0] flux, flux_next;
  logic [47:0] sum, sum_next, run, run_next, ph, ph_next, total, total_next;
  logic [48:0] target, target_next;
  logic        inv, inv_next;
  logic        done_next;
  result_t     result_next;

  // datapath temporaries
  logic [23:0] ov_lo, ov_hi, ov_w, diff, interp;
  logic        ov_ok;
  logic [48:0] rate_sum;
  logic [47:0] rate, run_new, sum_new;
  logic        load_ok;
  logic [SPEC_AW:0] mid_sum;
  logic        cum_below;

  assign n_eff  = eff_count(spec_cnt, CNT_W'(SPEC_DEPTH));
  assign m_eff  = eff_count(resp_cnt, CNT_W'(RESP_DEPTH));
  assign n_last = SPEC_AW'(n_eff - 1'b1);
  assign m_last = RESP_AW'(m_eff - 1'b1);
  assign busy   = (state != S_IDLE);

  always_comb begin
    ov_lo    = (resp_rdata.low > sl) ? resp_rdata.low : sl;
    ov_hi    = (resp_rdata.high < sh) ? resp_rdata.high : sh;
    ov_ok    = (resp_rdata.low < sh) && (resp_rdata.high > sl) && (ov_hi > ov_lo);
    ov_w     = ov_ok ? (ov_hi - ov_lo) : 24'd0;
    sum_new  = sat48({2'b00, sum} + {6'd0, mul_p[55:12]});
    rate_sum = {1'b0, ph[31:0], 16'd0} + {1'b0, mul_p[63:16]};
    rate     = (ph[47:32] != 16'd0) ? SAT48 : sat48({1'b0, rate_sum});
    run_new  = sat48({2'b00, run} + {2'b00, rate});
    diff     = (spec_rdata.high >= spec_rdata.low) ? (spec_rdata.high - spec_rdata.low)
                                                   : (spec_rdata.low - spec_rdata.high);
    interp   = inv ? (sl - mul_p[47:24]) : (sl + mul_p[47:24]);
    mid_sum  = {1'b0, lower} + {1'b0, upper};
    cum_below = ({1'b0, cum_rdata} < target);
    load_ok  = (cur.command == CMD_LOAD_SPEC) ? ({1'b0, cur.entry_index} < n_eff)
                                              : ({1'b0, cur.entry_index} < m_eff);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (cur.command)
          CMD_FOLD:   state_next = S_FI_RD;
          CMD_SAMPLE: state_next = S_SM_RD;
          default:    state_next = S_IDLE;
        endcase
      end
      S_FI_RD:    state_next = S_FI_LAT;
      S_FI_LAT:   state_next = S_FJ_RD;
      S_FJ_RD:    state_next = S_FJ_OV;
      S_FJ_OV:    state_next = S_FJ_ACC;
      S_FJ_ACC:   state_next = (j == m_last) ? S_FI_MH : S_FJ_RD;
      S_FI_MH:    state_next = S_FI_ML;
      S_FI_ML:    state_next = S_FI_RATE;
      S_FI_RATE:  state_next = (i == n_last) ? S_IDLE : S_FI_RD;
      S_SM_RD:    state_next = S_SM_TOT;
      S_SM_TOT:   state_next = S_SM_M2;
      S_SM_M2:    state_next = S_SM_TGT;
      S_SM_TGT:   state_next = (n_last != '0) ? S_SB_RD : S_SE_RD;
      S_SB_RD:    state_next = S_SB_CMP;
      S_SB_CMP:   state_next = (upper_next > lower_next) ? S_SB_RD : S_SE_RD;
      S_SE_RD:    state_next = S_SE_LAT;
      S_SE_LAT:   state_next = S_SE_OUT;
      S_SE_OUT:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    i_next      = i;
    j_next      = j;
    lower_next  = lower;
    upper_next  = upper;
    mid_next    = mid;
    sl_next     = sl;
    sh_next     = sh;
    flux_next   = flux;
    sum_next    = sum;
    run_next    = run;
    ph_next     = ph;
    total_next  = total;
    target_next = target;
    inv_next    = inv;
    done_next   = 1'b0;
    result_next = result;
    mul_a       = 32'd0;
    mul_b       = 32'd0;
    req             = '0;
    req.spec_addr   = cur.entry_index;
    req.resp_addr   = cur.entry_index;
    req.cum_addr    = i;
    req.spec_wdata  = '{low: cur.edge_low, high: cur.edge_high, weight: cur.bin_weight};
    req.resp_wdata  = '{low: cur.edge_low, high: cur.edge_high, weight: cur.bin_weight};
    req.cum_wdata   = run_new;
    case (state)
      S_DISPATCH: begin
        i_next   = '0;
        run_next = '0;
        if (cur.command == CMD_LOAD_SPEC || cur.command == CMD_LOAD_RESP) begin
          req.spec_we = load_ok && (cur.command == CMD_LOAD_SPEC);
          req.resp_we = load_ok && (cur.command == CMD_LOAD_RESP);
          done_next   = 1'b1;
          result_next = '{photon_energy: 24'd0, chosen_bin: 10'd0, total_rate: 48'd0,
                          result_status: !load_ok};
        end
      end
      S_FI_RD:  req.spec_addr = i;
      S_FI_LAT: begin
        sl_next   = spec_rdata.low;
        sh_next   = spec_rdata.high;
        flux_next = spec_rdata.weight;
        sum_next  = '0;
        j_next    = '0;
      end
      S_FJ_RD: req.resp_addr = j;
      S_FJ_OV: begin
        mul_a = resp_rdata.weight;
        mul_b = {8'd0, ov_w};
      end
      S_FJ_ACC: begin
        sum_next = sum_new;
        j_next   = j + 1'b1;
      end
      S_FI_MH: begin
        mul_a = flux;
        mul_b = {16'd0, sum[47:32]};
      end
      S_FI_ML: begin
        ph_next = mul_p[47:0];
        mul_a   = flux;
        mul_b   = sum[31:0];
      end
      S_FI_RATE: begin
        req.cum_we = 1'b1;
        run_next   = run_new;
        i_next     = i + 1'b1;
        if (i == n_last) begin
          done_next   = 1'b1;
          result_next = '{photon_energy: 24'd0, chosen_bin: 10'd0, total_rate: run_new,
                          result_status: 1'b0};
        end
      end
      S_SM_RD: req.cum_addr = n_last;
      S_SM_TOT: begin
        total_next = cum_rdata;
        mul_a      = {8'd0, cur.uniform_pick};
        mul_b      = {8'd0, cum_rdata[47:24]};
      end
      S_SM_M2: begin
        ph_next = mul_p[47:0];
        mul_a   = {8'd0, cur.uniform_pick};
        mul_b   = {8'd0, total[23:0]};
      end
      S_SM_TGT: begin
        target_next = {1'b0, ph} + {25'd0, mul_p[47:24]};
        lower_next  = '0;
        upper_next  = n_last;
      end
      S_SB_RD: begin
        mid_next     = mid_sum[SPEC_AW:1];
        req.cum_addr = mid_sum[SPEC_AW:1];
      end
      S_SB_CMP: begin
        if (cum_below) lower_next = mid + 1'b1;
        else upper_next = mid;
      end
      S_SE_RD: req.spec_addr = lower;
      S_SE_LAT: begin
        sl_next  = spec_rdata.low;
        inv_next = (spec_rdata.high < spec_rdata.low);
        mul_a    = {8'd0, cur.uniform_spread};
        mul_b    = {8'd0, diff};
      end
      S_SE_OUT: begin
        done_next   = 1'b1;
        result_next = '{photon_energy: interp, chosen_bin: lower, total_rate: total,
                        result_status: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      spec_cnt <= CNT_W'(1);
      resp_cnt <= CNT_W'(1);
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we && cfg_index == REG_SPEC_COUNT) spec_cnt <= cfg_data;
      if (cfg_we && cfg_index == REG_RESP_COUNT) resp_cnt <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) cur <= item;
    i      <= i_next;
    j      <= j_next;
    lower  <= lower_next;
    upper  <= upper_next;
    mid    <= mid_next;
    sl     <= sl_next;
    sh     <= sh_next;
    flux   <= flux_next;
    sum    <= sum_next;
    run    <= run_next;
    ph     <= ph_next;
    total  <= total_next;
    target <= target_next;
    inv    <= inv_next;
    result <= result_next;
  end

endmodule
`default_nettype wire
